// ===== design/dns_name_label_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// dns_name_label_encoder_defines
// Assertion macros for the DNS name label encoder, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_LABEL_ENCODER_DEFINES_SVH
`define DNS_NAME_LABEL_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DNLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dnle assertion failed");
// next-cycle implication
`define DNLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dnle assertion failed");
`else
`define DNLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DNLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/dnle_pkg.sv =====
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants of the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

  // label separator
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // flags of one command from the front end to the back end
  typedef struct packed {
    logic has_label;  // emit a length byte and the held characters
    logic term;       // emit the zero root byte afterwards
    logic too_long;   // label was truncated
    logic bank;       // label buffer bank holding the characters
  } cmd_flags_t;

  // back end hands a label buffer bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_release_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LEN,
    BK_CHAR,
    BK_TERM
  } back_state_t;

endpackage

// ===== design/dnle_front.sv =====
// ----------------------------------------------------------------------------
// dnle_front
// Accepts name characters, writes them into the label buffer and issues
// label and terminator commands to the back end.
// ----------------------------------------------------------------------------
module dnle_front import dnle_pkg::*; #(
  parameter int LABEL_MAX = 62,
  parameter int LEN_W     = 6,
  parameter int IDX_W     = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tlast,
  input  logic                 fifo_full,
  output logic                 push_valid,
  output cmd_flags_t           push_flags,
  output logic [LEN_W-1:0]     push_len,
  output logic                 wr_en,
  output logic [IDX_W:0]       wr_addr,
  output logic [7:0]           wr_data,
  input  bank_release_t        release_bank
);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             wbank_r, wbank_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic             accept;
  logic             is_dot;
  logic             room;

  assign accept    = in_tvalid && in_tready;
  assign is_dot    = (in_tdata == DOT_CHAR);
  assign room      = (len_r < LEN_W'(LABEL_MAX));
  assign in_tready = !fifo_full && !busy_r[wbank_r];
  assign wr_addr   = {wbank_r, len_r[IDX_W-1:0]};
  assign wr_data   = in_tdata;

  // classify the word and build the command
  always_comb begin
    logic [LEN_W-1:0] len_upd;
    logic             ovf_upd;
    len_upd    = len_r;
    ovf_upd    = ovf_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    wbank_nxt  = wbank_r;
    push_valid = 1'b0;
    push_flags = '0;
    push_len   = len_r;
    wr_en      = 1'b0;
    if (accept) begin
      if (is_dot) begin
        if (!in_tlast || len_r != '0) begin
          push_valid          = 1'b1;
          push_flags.has_label = 1'b1;
          push_flags.term     = in_tlast;
          push_flags.too_long = ovf_r;
          push_flags.bank     = wbank_r;
          push_len            = len_r;
          wbank_nxt           = ~wbank_r;
          len_nxt             = '0;
          ovf_nxt             = 1'b0;
        end else begin
          // lone dot, or a last dot after an empty label: terminator only
          push_valid      = 1'b1;
          push_flags.term = 1'b1;
        end
      end else begin
        if (room) begin
          wr_en   = 1'b1;
          len_upd = len_r + LEN_W'(1);
        end else begin
          ovf_upd = 1'b1;
        end
        if (in_tlast) begin
          push_valid           = 1'b1;
          push_flags.has_label = 1'b1;
          push_flags.term      = 1'b1;
          push_flags.too_long  = ovf_upd;
          push_flags.bank      = wbank_r;
          push_len             = len_upd;
          wbank_nxt            = ~wbank_r;
          len_nxt              = '0;
          ovf_nxt              = 1'b0;
        end else begin
          len_nxt = len_upd;
          ovf_nxt = ovf_upd;
        end
      end
    end
  end

  // bank ownership: set on a label command, cleared when the back end is done
  always_comb begin
    busy_nxt = busy_r;
    if (release_bank.valid) begin
      busy_nxt[release_bank.bank] = 1'b0;
    end
    if (push_valid && push_flags.has_label) begin
      busy_nxt[wbank_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      ovf_r   <= 1'b0;
      wbank_r <= 1'b0;
      busy_r  <= '0;
    end else begin
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      wbank_r <= wbank_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

// ===== design/dnle_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// dnle_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dnle_cmd_fifo import dnle_pkg::*; #(
  parameter int LEN_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  cmd_flags_t       push_flags,
  input  logic [LEN_W-1:0] push_len,
  output logic             full,
  output logic             pop_valid,
  output cmd_flags_t       pop_flags,
  output logic [LEN_W-1:0] pop_len,
  input  logic             pop
);

  cmd_flags_t       flags_q [2];
  logic [LEN_W-1:0] len_q [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_flags = flags_q[rptr_r];
  assign pop_len   = len_q[rptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      flags_q[wptr_r] <= push_flags;
      len_q[wptr_r]   <= push_len;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== design/dnle_back.sv =====
// ----------------------------------------------------------------------------
// dnle_back
// Holds the two-bank label buffer and plays commands out as wire bytes
// through a registered output stage.
// ----------------------------------------------------------------------------
module dnle_back import dnle_pkg::*; #(
  parameter int LEN_W     = 6,
  parameter int IDX_W     = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  cmd_flags_t       cmd_flags,
  input  logic [LEN_W-1:0] cmd_len,
  output logic             cmd_pop,
  input  logic             wr_en,
  input  logic [IDX_W:0]   wr_addr,
  input  logic [7:0]       wr_data,
  output bank_release_t    release_bank,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,   // wire_byte
  output logic             out_tlast,
  output logic [1:0]       out_tuser    // [0] name_end, [1] label_too_long
);

  localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

  logic [7:0]       mem [MEM_DEPTH];
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] rd_idx;

  back_state_t      state_r, state_nxt;
  cmd_flags_t       cur_flags_r, cur_flags_nxt;
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;
  logic [1:0]       out_user_r, out_user_nxt;
  logic             load;

  assign load       = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // label buffer, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[{cur_flags_r.bank, rd_idx}];
  end

  // sequencer and output stage
  always_comb begin
    state_nxt     = state_r;
    cur_flags_nxt = cur_flags_r;
    cur_len_nxt   = cur_len_r;
    idx_nxt       = idx_r;
    cmd_pop       = 1'b0;
    release_bank  = '0;
    rd_idx        = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop       = 1'b1;
          cur_flags_nxt = cmd_flags;
          cur_len_nxt   = cmd_len;
          state_nxt     = cmd_flags.has_label ? BK_LEN : BK_TERM;
        end
      end
      BK_LEN: begin
        // first character is fetched while the length byte goes out
        if (load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 8'(cur_len_r);
          out_user_nxt  = {cur_flags_r.too_long, 1'b0};
          if (cur_len_r != '0) begin
            out_last_nxt = 1'b0;
            idx_nxt      = '0;
            state_nxt    = BK_CHAR;
          end else begin
            release_bank.valid = 1'b1;
            release_bank.bank  = cur_flags_r.bank;
            out_last_nxt       = !cur_flags_r.term;
            state_nxt          = cur_flags_r.term ? BK_TERM : BK_IDLE;
          end
        end
      end
      BK_CHAR: begin
        rd_idx = idx_r;
        if (load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_data_r;
          out_user_nxt  = 2'b00;
          if (LEN_W'(idx_r) + LEN_W'(1) == cur_len_r) begin
            release_bank.valid = 1'b1;
            release_bank.bank  = cur_flags_r.bank;
            out_last_nxt       = !cur_flags_r.term;
            state_nxt          = cur_flags_r.term ? BK_TERM : BK_IDLE;
          end else begin
            out_last_nxt = 1'b0;
            idx_nxt      = idx_r + IDX_W'(1);
            rd_idx       = idx_nxt;
          end
        end
      end
      BK_TERM: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 8'h00;
          out_last_nxt  = 1'b1;
          out_user_nxt  = 2'b01;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_flags_r <= cur_flags_nxt;
    cur_len_r   <= cur_len_nxt;
    idx_r       <= idx_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_user_r  <= out_user_nxt;
  end

endmodule

// ===== design/dns_name_label_encoder.sv =====
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Dotted domain name in, DNS wire-format labels out.
// ----------------------------------------------------------------------------
// Characters of a name arrive one per word and are held in a two-bank label
// buffer; a dot or the last word of a name (tlast) queues a command, and the
// back end sends the length byte, the held characters and, at the end of the
// name, the zero root byte. Input runs at one character per cycle while the
// front end can fill the free bank; output runs at one byte per cycle while
// out_tready is high, plus a pass through the idle state per command for the
// back end to fetch it from the two-entry queue. Input stalls only when the
// bank being filled is still being played out or the queue is full.
// Characters beyond LABEL_MAX in a label are dropped and the length byte
// carries label_too_long.
module dns_name_label_encoder import dnle_pkg::*; #(
  parameter int LABEL_MAX = 62
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // character
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // wire_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [0] name_end, [1] label_too_long
);

`include "dns_name_label_encoder_defines.svh"

  localparam int LEN_W = $clog2(LABEL_MAX + 1);
  localparam int IDX_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  logic             fifo_full;
  logic             push_valid;
  cmd_flags_t       push_flags;
  logic [LEN_W-1:0] push_len;
  logic             cmd_valid;
  cmd_flags_t       cmd_flags;
  logic [LEN_W-1:0] cmd_len;
  logic             cmd_pop;
  logic             wr_en;
  logic [IDX_W:0]   wr_addr;
  logic [7:0]       wr_data;
  bank_release_t    release_bank;

  // front end
  dnle_front #(
    .LABEL_MAX (LABEL_MAX),
    .LEN_W     (LEN_W),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .fifo_full    (fifo_full),
    .push_valid   (push_valid),
    .push_flags   (push_flags),
    .push_len     (push_len),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .release_bank (release_bank)
  );

  // command queue
  dnle_cmd_fifo #(
    .LEN_W (LEN_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_flags (push_flags),
    .push_len   (push_len),
    .full       (fifo_full),
    .pop_valid  (cmd_valid),
    .pop_flags  (cmd_flags),
    .pop_len    (cmd_len),
    .pop        (cmd_pop)
  );

  // back end
  dnle_back #(
    .LEN_W     (LEN_W),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_flags    (cmd_flags),
    .cmd_len      (cmd_len),
    .cmd_pop      (cmd_pop),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .release_bank (release_bank),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser)
  );

  // root byte is zero and closes its run
  `DNLE_ASSERT_IMP(a_root_byte, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == 8'h00 && out_tlast)
  // a truncated label reports the full limit as its length
  `DNLE_ASSERT_IMP(a_trunc_len, clk, rst_n, out_tvalid && out_tuser[1], out_tdata == 8'(LABEL_MAX))
  // the last word of a name always leaves a command queued
  `DNLE_ASSERT_NXT(a_last_queued, clk, rst_n, in_tvalid && in_tready && in_tlast, cmd_valid)

endmodule
